>>> sv/assert_macros.svh
// Assertion macros used by gmp_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define GMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gmp assertion failed");

// same, on the block clock and reset
`define GMP_CHECK(lbl, prop) `GMP_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

>>> sv/gmp_pkg.sv
// Package for the grid minimum path sum block: sizes, widths and the
// shared-unit request types. No dependencies.
`default_nettype none

package gmp_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int WEIGHT_BITS = 8;

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TOT_W  = ADDR_W + 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);

    localparam int DIST_W = 15;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam int SUM_W  = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

    localparam int IN_W   = 8;
    localparam int POS_W  = 6;
    localparam int CFG_W  = 7;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic                   scan;
        logic [DIST_W-1:0]      a;
        logic [DIST_W-1:0]      b;
        logic                   has_a;
        logic                   has_b;
        logic [WEIGHT_BITS-1:0] w;
        logic [DIST_W:0]        best;
    } t_unit_req;

    typedef struct packed {
        logic [DIST_W-1:0] res;
        logic              less;
    } t_unit_rsp;

endpackage

`default_nettype wire

>>> sv/gmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/gmp_unit.sv
// Shared arithmetic unit: min-of-neighbors plus weight with saturation for
// the two passes, forward plus backward minus weight and compare for the scan.
// Depends on gmp_pkg.
`default_nettype none

module gmp_unit (
    input  wire gmp_pkg::t_unit_req i_req,
    output gmp_pkg::t_unit_rsp      o_rsp
);
    import gmp_pkg::*;

    logic [DIST_W-1:0] base;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  diff;
    logic [SUM_W-1:0]  w_ext;
    logic [DIST_W-1:0] res;

    always_comb begin
        base = '0;
        if (i_req.has_a) begin
            base = i_req.a;
        end
        if (i_req.has_b && (!i_req.has_a || (i_req.b < i_req.a))) begin
            base = i_req.b;
        end

        w_ext = SUM_W'(i_req.w);
        if (i_req.scan) begin
            sum  = SUM_W'(i_req.a) + SUM_W'(i_req.b);
            diff = (sum >= w_ext) ? (sum - w_ext) : '0;
        end else begin
            sum  = SUM_W'(base) + w_ext;
            diff = sum;
        end

        res = (diff > SUM_W'(DIST_MAX)) ? DIST_MAX : diff[DIST_W-1:0];
    end

    assign o_rsp.res  = res;
    assign o_rsp.less = ({1'b0, res} < i_req.best);

endmodule

`default_nettype wire

>>> sv/grid_min_path_sum_meet_middle.sv
// One cell is taken per cycle while loading; after the last cell, the forward, backward
// and scan passes each step through a read state and a write or compare state per cell,
// through the shared unit and the registered RAM reads, then the done state loads the output.
// No new cells are taken during the passes or while an untaken result stalls the done state.
// Reset: synchronous, active low; grid is 2x2, load count cleared, no RAM clear.
// Depends on gmp_pkg, gmp_ram and gmp_unit.
`default_nettype none

module grid_min_path_sum_meet_middle (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [gmp_pkg::IN_W-1:0]     i_cell_weight,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [gmp_pkg::POS_W-1:0]    o_meet_row,
    output logic      [gmp_pkg::POS_W-1:0]    o_meet_col,
    output logic      [gmp_pkg::DIST_W-1:0]   o_shortest_distance,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gmp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [gmp_pkg::APB_DW-1:0]   pwdata,
    output logic      [gmp_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import gmp_pkg::*;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_FWD_RD  = 3'd1;
    localparam logic [2:0] S_FWD_WR  = 3'd2;
    localparam logic [2:0] S_BWD_RD  = 3'd3;
    localparam logic [2:0] S_BWD_WR  = 3'd4;
    localparam logic [2:0] S_SCN_RD  = 3'd5;
    localparam logic [2:0] S_SCN_CMP = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]        r_state;
    logic [CFG_W-1:0]  r_rows_cfg;
    logic [CFG_W-1:0]  r_cols_cfg;
    logic [TOT_W-1:0]  r_load;
    logic [ADDR_W-1:0] r_idx;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [DIST_W-1:0] r_prev;
    logic [DIST_W:0]   r_best_sum;
    logic [ROW_W-1:0]  r_best_row;
    logic [COL_W-1:0]  r_best_col;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_col;
    logic [DIST_W-1:0] r_out_dist;

    logic [RCNT_W-1:0] rows;
    logic [CCNT_W-1:0] cols;
    logic [ROW_W-1:0]  rows_m1;
    logic [COL_W-1:0]  cols_m1;
    logic [TOT_W-1:0]  total;
    logic [ADDR_W-1:0] cols_a;
    logic              in_acc;
    logic              cfg_we;
    logic              at_last;

    logic [ADDR_W-1:0]      fwd_raddr;
    logic [ADDR_W-1:0]      bwd_raddr;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [DIST_W-1:0]      fwd_rdata;
    logic [DIST_W-1:0]      bwd_rdata;

    t_unit_req unit_req;
    t_unit_rsp unit_rsp;

    always_comb begin
        if (r_rows_cfg == '0) begin
            rows = RCNT_W'(1);
        end else if (32'(r_rows_cfg) > MAX_ROWS) begin
            rows = RCNT_W'(MAX_ROWS);
        end else begin
            rows = RCNT_W'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            cols = CCNT_W'(1);
        end else if (32'(r_cols_cfg) > MAX_COLS) begin
            cols = CCNT_W'(MAX_COLS);
        end else begin
            cols = CCNT_W'(r_cols_cfg);
        end
    end

    assign rows_m1 = ROW_W'(rows - RCNT_W'(1));
    assign cols_m1 = COL_W'(cols - CCNT_W'(1));
    assign total   = TOT_W'(rows) * TOT_W'(cols);
    assign cols_a  = ADDR_W'(cols);
    assign at_last = (r_row == rows_m1) && (r_col == cols_m1);

    assign o_ready = (r_state == S_LOAD);
    assign in_acc  = i_valid && o_ready;
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_ROWS: prdata = APB_DW'(r_rows_cfg);
            REG_COLS: prdata = APB_DW'(r_cols_cfg);
            default:  prdata = '0;
        endcase
    end

    assign fwd_raddr = (r_state == S_FWD_RD) ? (r_idx - cols_a) : r_idx;
    assign bwd_raddr = (r_state == S_BWD_RD) ? (r_idx + cols_a) : r_idx;

    gmp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CELLS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load[ADDR_W-1:0]),
        .i_wdata (WEIGHT_BITS'(i_cell_weight)),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    gmp_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FWD_WR),
        .i_waddr (r_idx),
        .i_wdata (unit_rsp.res),
        .i_raddr (fwd_raddr),
        .o_rdata (fwd_rdata)
    );

    gmp_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_bwd_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_BWD_WR),
        .i_waddr (r_idx),
        .i_wdata (unit_rsp.res),
        .i_raddr (bwd_raddr),
        .o_rdata (bwd_rdata)
    );

    always_comb begin
        unit_req.scan  = (r_state == S_SCN_CMP);
        unit_req.a     = (r_state == S_BWD_WR) ? bwd_rdata : fwd_rdata;
        unit_req.b     = (r_state == S_SCN_CMP) ? bwd_rdata : r_prev;
        unit_req.w     = w_rdata;
        unit_req.best  = r_best_sum;
        if (r_state == S_BWD_WR) begin
            unit_req.has_a = (r_row != rows_m1);
            unit_req.has_b = (r_col != cols_m1);
        end else begin
            unit_req.has_a = (r_row != '0);
            unit_req.has_b = (r_col != '0);
        end
    end

    gmp_unit u_unit (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_rows_cfg  <= CFG_W'(2);
            r_cols_cfg  <= CFG_W'(2);
            r_load      <= '0;
            r_idx       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_best_sum  <= '1;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (paddr[2] == REG_ROWS) begin
                    r_rows_cfg <= pwdata[CFG_W-1:0];
                end else begin
                    r_cols_cfg <= pwdata[CFG_W-1:0];
                end
                r_load <= '0;
            end

            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if ((r_load + TOT_W'(1)) == total) begin
                            r_load  <= '0;
                            r_idx   <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_FWD_RD;
                        end else begin
                            r_load <= r_load + TOT_W'(1);
                        end
                    end
                end
                S_FWD_RD: begin
                    r_state <= S_FWD_WR;
                end
                S_FWD_WR: begin
                    r_prev <= unit_rsp.res;
                    if (at_last) begin
                        r_state <= S_BWD_RD;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_FWD_RD;
                        if (r_col == cols_m1) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                S_BWD_RD: begin
                    r_state <= S_BWD_WR;
                end
                S_BWD_WR: begin
                    r_prev <= unit_rsp.res;
                    if (r_idx == '0) begin
                        r_best_sum <= '1;
                        r_state    <= S_SCN_RD;
                    end else begin
                        r_idx   <= r_idx - ADDR_W'(1);
                        r_state <= S_BWD_RD;
                        if (r_col == '0) begin
                            r_col <= cols_m1;
                            r_row <= r_row - ROW_W'(1);
                        end else begin
                            r_col <= r_col - COL_W'(1);
                        end
                    end
                end
                S_SCN_RD: begin
                    r_state <= S_SCN_CMP;
                end
                S_SCN_CMP: begin
                    if (unit_rsp.less) begin
                        r_best_sum <= {1'b0, unit_rsp.res};
                        r_best_row <= r_row;
                        r_best_col <= r_col;
                    end
                    if (at_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + ADDR_W'(1);
                        r_state <= S_SCN_RD;
                        if (r_col == cols_m1) begin
                            r_col <= '0;
                            r_row <= r_row + ROW_W'(1);
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
            r_out_row  <= POS_W'(r_best_row);
            r_out_col  <= POS_W'(r_best_col);
            r_out_dist <= r_best_sum[DIST_W-1:0];
        end
    end

    assign o_valid             = r_out_valid;
    assign o_meet_row          = r_out_row;
    assign o_meet_col          = r_out_col;
    assign o_shortest_distance = r_out_dist;

endmodule

`default_nettype wire

>>> sv/gmp_checker.sv
// Port-level checker for grid_min_path_sum_meet_middle, attached by bind.
// Depends on gmp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gmp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_ready,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [gmp_pkg::POS_W-1:0]    o_meet_row,
    input wire logic [gmp_pkg::POS_W-1:0]    o_meet_col,
    input wire logic [gmp_pkg::DIST_W-1:0]   o_shortest_distance
);
    import gmp_pkg::*;

    logic [2*POS_W+DIST_W-1:0] out_payload;

    assign out_payload = {o_meet_row, o_meet_col, o_shortest_distance};

    `GMP_CHECK(a_out_hold, o_valid && !i_ready |=> o_valid)
    `GMP_CHECK(a_out_stable, o_valid && !i_ready |=> $stable(out_payload))
    `GMP_CHECK(a_busy_after_request, $fell(o_ready) |-> $past(i_valid))
    `GMP_CHECK(a_result_from_passes, $rose(o_valid) |-> $past(!o_ready))

endmodule

bind grid_min_path_sum_meet_middle gmp_checker u_gmp_checker (.*);

`default_nettype wire

>>> tb/tb_grid_min_path_sum_meet_middle.sv
`timescale 1ns / 100ps
// Self-checking bench for grid_min_path_sum_meet_middle: directed and random grid
// frames, each result checked against a behavioral model of the three DP passes,
// or against the table value for flagged directed cells. Depends on gmp_pkg and the block's RTL.

module tb_grid_min_path_sum_meet_middle;
    import gmp_pkg::*;

    localparam int QUIET_LIMIT = 100000;
    localparam int LONG_HOLD   = 3000;
    localparam int RAND_ITEMS  = 1100;
    localparam int DIST_CAP    = int'(DIST_MAX);

    typedef struct packed {
        logic [POS_W-1:0]  meet_row;
        logic [POS_W-1:0]  meet_col;
        logic [DIST_W-1:0] distance;
    } t_meet;

    typedef enum logic [1:0] {ENT_CELL, ENT_ROWS, ENT_COLS} t_ent_kind;

    typedef struct packed {
        t_ent_kind  kind;
        logic [7:0] value;
        logic       check;
        t_meet      want;
    } t_stim_row;

    localparam t_stim_row STIM_TBL [25] = '{
        '{ENT_CELL, 8'd0,   1'b0, '0},
        '{ENT_CELL, 8'd0,   1'b0, '0},
        '{ENT_CELL, 8'd0,   1'b0, '0},
        '{ENT_CELL, 8'd0,   1'b1, '{6'd0, 6'd0, 15'd0}},
        '{ENT_CELL, 8'd255, 1'b0, '0},
        '{ENT_CELL, 8'd255, 1'b0, '0},
        '{ENT_CELL, 8'd255, 1'b0, '0},
        '{ENT_CELL, 8'd255, 1'b1, '{6'd0, 6'd0, 15'd765}},
        '{ENT_ROWS, 8'd0,   1'b0, '0},
        '{ENT_COLS, 8'd0,   1'b0, '0},
        '{ENT_CELL, 8'd0,   1'b1, '{6'd0, 6'd0, 15'd0}},
        '{ENT_CELL, 8'd255, 1'b1, '{6'd0, 6'd0, 15'd255}},
        '{ENT_ROWS, 8'd1,   1'b0, '0},
        '{ENT_COLS, 8'd2,   1'b0, '0},
        '{ENT_CELL, 8'd255, 1'b0, '0},
        '{ENT_CELL, 8'd0,   1'b1, '{6'd0, 6'd0, 15'd255}},
        '{ENT_ROWS, 8'd2,   1'b0, '0},
        '{ENT_CELL, 8'd9,   1'b0, '0},
        '{ENT_CELL, 8'd9,   1'b0, '0},
        '{ENT_CELL, 8'd9,   1'b0, '0},
        '{ENT_COLS, 8'd2,   1'b0, '0},
        '{ENT_CELL, 8'd1,   1'b0, '0},
        '{ENT_CELL, 8'd2,   1'b0, '0},
        '{ENT_CELL, 8'd3,   1'b0, '0},
        '{ENT_CELL, 8'd4,   1'b0, '0}
    };

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [IN_W-1:0]   i_cell_weight = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [POS_W-1:0]  o_meet_row;
    logic [POS_W-1:0]  o_meet_col;
    logic [DIST_W-1:0] o_shortest_distance;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [CFG_W-1:0]       grid_rows_cfg = CFG_W'(2);
    logic [CFG_W-1:0]       grid_cols_cfg = CFG_W'(2);
    logic [WEIGHT_BITS-1:0] cell_w   [CELLS];
    logic [DIST_W-1:0]      dist_fwd [CELLS];
    logic [DIST_W-1:0]      dist_bwd [CELLS];
    int                     load_cnt = 0;

    t_meet pending_meets [$];
    t_meet pinned_want   = '0;
    bit    pinned_en     = 1'b0;
    bit    hold_req      = 1'b0;
    int    send_idle_pct = 29;
    int    recv_idle_pct = 84;
    int    quiet_cycles  = 0;
    int    mismatches    = 0;

    grid_min_path_sum_meet_middle i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cell_weight       (i_cell_weight),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_meet_row          (o_meet_row),
        .o_meet_col          (o_meet_col),
        .o_shortest_distance (o_shortest_distance),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int grid_dim(input logic [CFG_W-1:0] v, input int lim);
        if (v == '0) return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic int sat(input int v);
        return (v > DIST_CAP) ? DIST_CAP : v;
    endfunction

    function automatic t_meet solve_grid(input int rows, input int cols);
        int    idx;
        int    best;
        int    fb;
        int    s;
        int    best_sum;
        int    best_idx;
        bit    have;
        t_meet res;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                idx  = r * cols + c;
                best = 0;
                have = 1'b0;
                if (r > 0) begin
                    best = int'(dist_fwd[idx - cols]);
                    have = 1'b1;
                end
                if (c > 0 && (!have || int'(dist_fwd[idx - 1]) < best))
                    best = int'(dist_fwd[idx - 1]);
                dist_fwd[idx] = DIST_W'(sat(best + int'(cell_w[idx])));
            end
        end
        for (int r = rows - 1; r >= 0; r--) begin
            for (int c = cols - 1; c >= 0; c--) begin
                idx  = r * cols + c;
                best = 0;
                have = 1'b0;
                if (r + 1 < rows) begin
                    best = int'(dist_bwd[idx + cols]);
                    have = 1'b1;
                end
                if (c + 1 < cols && (!have || int'(dist_bwd[idx + 1]) < best))
                    best = int'(dist_bwd[idx + 1]);
                dist_bwd[idx] = DIST_W'(sat(best + int'(cell_w[idx])));
            end
        end
        best_sum = 'hFFFF;
        best_idx = 0;
        for (int i = 0; i < rows * cols; i++) begin
            fb = int'(dist_fwd[i]) + int'(dist_bwd[i]);
            s  = (fb >= int'(cell_w[i])) ? fb - int'(cell_w[i]) : 0;
            s  = sat(s);
            if (s < best_sum) begin
                best_sum = s;
                best_idx = i;
            end
        end
        res.meet_row = POS_W'(best_idx / cols);
        res.meet_col = POS_W'(best_idx % cols);
        res.distance = DIST_W'(best_sum);
        return res;
    endfunction

    function automatic bit absorb_weight(input logic [IN_W-1:0] w, output t_meet res);
        int rows;
        int cols;
        int total;
        rows  = grid_dim(grid_rows_cfg, MAX_ROWS);
        cols  = grid_dim(grid_cols_cfg, MAX_COLS);
        total = rows * cols;
        res   = '0;
        if (load_cnt >= total) load_cnt = 0;
        cell_w[load_cnt] = WEIGHT_BITS'(w);
        load_cnt++;
        if (load_cnt < total) return 1'b0;
        res      = solve_grid(rows, cols);
        load_cnt = 0;
        return 1'b1;
    endfunction

    function automatic logic [IN_W-1:0] rand_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return IN_W'($urandom_range(3));
            default: return IN_W'($urandom_range(255));
        endcase
    endfunction

    always @(posedge i_clk) begin : port_watch
        t_meet seen;
        t_meet want;
        t_meet pred;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (i_valid && o_ready) begin
                if (absorb_weight(i_cell_weight, pred))
                    pending_meets.push_back(pinned_en ? pinned_want : pred);
            end
            if (o_valid && i_ready) begin
                seen = '{o_meet_row, o_meet_col, o_shortest_distance};
                if (pending_meets.size() == 0) begin
                    $error("unexpected result: row %0d col %0d dist %0d",
                           seen.meet_row, seen.meet_col, seen.distance);
                    mismatches++;
                end else begin
                    want = pending_meets.pop_front();
                    if (seen.meet_row !== want.meet_row) begin
                        $error("meet_row: expected %0d, got %0d", want.meet_row, seen.meet_row);
                        mismatches++;
                    end
                    if (seen.meet_col !== want.meet_col) begin
                        $error("meet_col: expected %0d, got %0d", want.meet_col, seen.meet_col);
                        mismatches++;
                    end
                    if (seen.distance !== want.distance) begin
                        $error("shortest_distance: expected %0d, got %0d",
                               want.distance, seen.distance);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // hold valid and payload until the request is taken
    task automatic push_weight(input logic [IN_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cell_weight <= w;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int cells;
        while (pending_meets.size() != 0) @(negedge i_clk);
        cells = grid_dim(grid_rows_cfg, MAX_ROWS) * grid_dim(grid_cols_cfg, MAX_COLS);
        repeat (6 * cells + 32) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [0:0] reg_idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_ROWS)
            grid_rows_cfg = val;
        else
            grid_cols_cfg = val;
        load_cnt = 0;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(val)) begin
            $error("%s: expected %0d, got %0d",
                   (reg_idx == REG_ROWS) ? "grid_rows" : "grid_cols", val, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int sent;
        int cells;
        int frames;
        int mode;
        int rv;
        int cv;
        bit held;
        sent = 0;
        held = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (STIM_TBL[k]) begin
            if (STIM_TBL[k].kind == ENT_CELL) begin
                pinned_en   = STIM_TBL[k].check;
                pinned_want = STIM_TBL[k].want;
                push_weight(STIM_TBL[k].value);
                pinned_en   = 1'b0;
            end else begin
                i_valid <= 1'b0;
                wait_drained();
                cfg_write((STIM_TBL[k].kind == ENT_ROWS) ? REG_ROWS : REG_COLS,
                          CFG_W'(STIM_TBL[k].value));
            end
        end

        while (sent < RAND_ITEMS) begin
            mode = sent * 3 / RAND_ITEMS;
            i_valid <= 1'b0;
            wait_drained();
            @(posedge i_clk);
            send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 84 : 0;
            recv_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 29 : 0;
            @(negedge i_clk);
            case ($urandom_range(9))
                0: begin rv = $urandom_range(64, 127); cv = $urandom_range(0, 3); end
                1: begin rv = $urandom_range(0, 3); cv = $urandom_range(64, 127); end
                2: begin rv = 64; cv = $urandom_range(1, 2); end
                3: begin rv = 1; cv = 64; end
                default: begin rv = $urandom_range(0, 6); cv = $urandom_range(0, 6); end
            endcase
            frames = $urandom_range(1, 4);
            if (mode == 2 && !held) begin
                // long output stall on a few small frames so the input backs up
                rv = 2;
                cv = 2;
                frames = 4;
                held = 1'b1;
                @(posedge i_clk);
                hold_req = 1'b1;
                @(negedge i_clk);
            end
            cfg_write(REG_ROWS, CFG_W'(rv));
            cfg_write(REG_COLS, CFG_W'(cv));
            cells = grid_dim(grid_rows_cfg, MAX_ROWS) * grid_dim(grid_cols_cfg, MAX_COLS);
            if (cells > 32) frames = 1;
            repeat (frames * cells) begin
                push_weight(rand_weight());
                sent++;
            end
            // drop a partial frame; the next register write discards it
            if (cells > 1 && $urandom_range(3) == 0) begin
                repeat ($urandom_range(1, cells - 1)) begin
                    push_weight(rand_weight());
                    sent++;
                end
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
